[rtl/fantc_pkg.sv]
// Shared types, codes and constants for the fan tach/PWM controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package fantc_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_TACH    = 3'd1,
        OP_SPEED   = 3'd2,
        OP_PWR_ON  = 3'd3,
        OP_PWR_OFF = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DUTY,
        B_CALC,
        B_DIV,
        B_STALL,
        B_EMIT
    } bstate_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] group;
        logic [6:0] speed;
    } cmd_t;

    typedef struct packed {
        logic [15:0] interval;
        logic [15:0] min_pulses;
        logic [15:0] stall_timeout;
    } cfg_t;

    localparam logic [1:0]  CFG_INTERVAL   = 2'd0;
    localparam logic [1:0]  CFG_MIN_PULSES = 2'd1;
    localparam logic [1:0]  CFG_STALL      = 2'd2;

    localparam logic [15:0] RST_INTERVAL   = 16'd1000;
    localparam logic [15:0] RST_MIN_PULSES = 16'd10;
    localparam logic [15:0] RST_STALL      = 16'd2000;

    localparam logic [15:0] RPM_SCALE      = 16'd60000;
    localparam logic [6:0]  SPEED_MAX      = 7'd100;
    localparam logic [6:0]  SPEED_DEFAULT  = 7'd50;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    // 1023 * round_up(2^24 / 100); exact for speeds 0..100
    localparam logic [27:0] DUTY_RECIP     = 28'd171631779;

    localparam int          FIFO_DEPTH     = 4;
    localparam int          FIFO_AW        = 2;

    localparam int          IN_TDATA_W     = 16;
    localparam int          OUT_TDATA_W    = 56;

    function automatic logic [9:0] duty_of(input logic [6:0] spd);
        logic [34:0] prod;
        prod = 35'(spd) * 35'(DUTY_RECIP);
        return prod[33:24];
    endfunction

endpackage

`default_nettype wire

[rtl/fantc_front.sv]
// Input side: accepts stream words, drops those with no effect, clamps speed.
// Depends on fantc_pkg; feeds fantc_fifo.
`default_nettype none

module fantc_front
    import fantc_pkg::*;
#(
    parameter int GROUPS = 2
) (
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [2:0]            s_tuser,   // operation
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // group[2:0], speed[9:3]
    input  wire logic                  q_full,
    output logic                       q_push,
    output cmd_t                       q_cmd
);

    op_t        op;
    logic [2:0] grp;
    logic [6:0] spd;
    logic       grp_ok;
    logic       keep;

    assign op     = op_t'(s_tuser);
    assign grp    = s_tdata[2:0];
    assign spd    = s_tdata[9:3];
    assign grp_ok = {1'b0, grp} < 4'(GROUPS);

    always_comb begin
        case (op)
            OP_TICK, OP_PWR_ON, OP_PWR_OFF: keep = 1'b1;
            OP_TACH, OP_SPEED:              keep = grp_ok;
            default:                        keep = 1'b0;
        endcase
    end

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full && keep;
    assign q_cmd.op    = op;
    assign q_cmd.group = grp;
    assign q_cmd.speed = (spd > SPEED_MAX) ? SPEED_MAX : spd;

endmodule

`default_nettype wire

[rtl/fantc_fifo.sv]
// Short command queue between the front and back ends.
// Depends on fantc_pkg for the command type and depth.
`default_nettype none

module fantc_fifo
    import fantc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg,  count_next;

    assign full       = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/fantc_back.sv]
// Execution side: per-group state, RPM divider, duty mapping and result register.
// Depends on fantc_pkg; pops commands from fantc_fifo.
`default_nettype none

module fantc_back
    import fantc_pkg::*;
#(
    parameter  int GROUPS = 2,
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  cfg_t                        cfg,
    input  wire logic                   q_valid,
    input  cmd_t                        q_cmd,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast
);

    bstate_t      state_reg, state_next;
    cmd_t         cmd_reg, cmd_next;
    logic [GW-1:0] gidx_reg, gidx_next;
    logic [31:0]  time_reg, time_next;
    logic [15:0]  since_reg, since_next;
    logic [16:0]  den_reg, den_next;
    logic [31:0]  quot_reg, quot_next;
    logic [16:0]  rem_reg, rem_next;
    logic [4:0]   div_cnt_reg, div_cnt_next;
    logic         power_reg, power_next;

    logic [15:0]  pulse_reg [GROUPS];
    logic [31:0]  lvt_reg   [GROUPS];
    logic [31:0]  rpm_reg   [GROUPS];
    logic [6:0]   spd_reg   [GROUPS];
    logic [9:0]   duty_reg  [GROUPS];

    logic         pulse_we, lvt_we, rpm_we, spd_we, duty_we;
    logic [15:0]  pulse_next;
    logic [31:0]  lvt_next, rpm_next;
    logic [6:0]   spd_next;
    logic [9:0]   duty_next;

    logic [GW-1:0] sel_idx;
    logic [15:0]  pulse_cur;
    logic [6:0]   spd_cur, spd_eff;
    logic [15:0]  since_inc;
    logic         upd;
    logic         last_grp;
    logic         out_free;
    logic         out_load;
    logic [17:0]  rem_sh, rem_sub;
    logic         rem_ge;
    logic [31:0]  quot_step;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    assign sel_idx   = (state_reg == B_IDLE) ? q_cmd.group[GW-1:0] : gidx_reg;
    assign pulse_cur = pulse_reg[sel_idx];
    assign spd_cur   = spd_reg[sel_idx];
    assign since_inc = (since_reg == COUNT_MAX) ? since_reg : since_reg + 16'd1;
    assign upd       = since_inc >= cfg.interval;
    assign last_grp  = (cmd_reg.op == OP_SPEED) || (gidx_reg == GW'(GROUPS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign spd_eff   = (cmd_reg.op == OP_PWR_ON && spd_cur == 7'd0) ? SPEED_DEFAULT : spd_cur;
    assign rem_sh    = {rem_reg, quot_reg[31]};
    assign rem_sub   = rem_sh - {1'b0, den_reg};
    assign rem_ge    = rem_sh >= {1'b0, den_reg};
    assign quot_step = {quot_reg[30:0], rem_ge};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.op)
                        OP_TICK:                        state_next = upd ? B_CALC : B_IDLE;
                        OP_SPEED, OP_PWR_ON, OP_PWR_OFF: state_next = B_DUTY;
                        default:                        state_next = B_IDLE;
                    endcase
                end
            end
            B_DUTY:  state_next = B_EMIT;
            B_CALC:  state_next = (pulse_cur > cfg.min_pulses) ? B_DIV : B_STALL;
            B_DIV:   state_next = (div_cnt_reg == 5'd0) ? B_STALL : B_DIV;
            B_STALL: state_next = B_EMIT;
            B_EMIT: begin
                if (out_free) begin
                    if (last_grp) begin
                        state_next = B_IDLE;
                    end else if (cmd_reg.op == OP_TICK) begin
                        state_next = B_CALC;
                    end else begin
                        state_next = B_DUTY;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop        = 1'b0;
        out_load     = 1'b0;
        cmd_next     = cmd_reg;
        gidx_next    = gidx_reg;
        time_next    = time_reg;
        since_next   = since_reg;
        den_next     = den_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        power_next   = power_reg;
        pulse_we     = 1'b0;
        lvt_we       = 1'b0;
        rpm_we       = 1'b0;
        spd_we       = 1'b0;
        duty_we      = 1'b0;
        pulse_next   = pulse_cur;
        lvt_next     = time_reg;
        rpm_next     = quot_step;
        spd_next     = spd_eff;
        duty_next    = '0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    gidx_next = '0;
                    case (q_cmd.op)
                        OP_TICK: begin
                            time_next = time_reg + 32'd1;
                            if (upd) begin
                                since_next = '0;
                                den_next   = {since_inc, 1'b0};
                            end else begin
                                since_next = since_inc;
                            end
                        end
                        OP_TACH: begin
                            pulse_we   = 1'b1;
                            pulse_next = (pulse_cur == COUNT_MAX) ? pulse_cur
                                                                  : pulse_cur + 16'd1;
                        end
                        OP_SPEED: begin
                            spd_we    = 1'b1;
                            spd_next  = q_cmd.speed;
                            gidx_next = sel_idx;
                        end
                        OP_PWR_ON:  power_next = 1'b1;
                        OP_PWR_OFF: power_next = 1'b0;
                        default: ;
                    endcase
                end
            end
            B_DUTY: begin
                spd_we    = 1'b1;
                duty_we   = 1'b1;
                duty_next = power_reg ? duty_of(spd_eff) : 10'd0;
            end
            B_CALC: begin
                quot_next    = 32'(pulse_cur) * 32'(RPM_SCALE);
                rem_next     = '0;
                div_cnt_next = 5'd31;
            end
            B_DIV: begin
                quot_next    = quot_step;
                rem_next     = rem_ge ? rem_sub[16:0] : rem_sh[16:0];
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0) begin
                    rpm_we = 1'b1;
                    lvt_we = 1'b1;
                end
            end
            B_STALL: begin
                pulse_we   = 1'b1;
                pulse_next = '0;
                if ((time_reg - lvt_reg[sel_idx]) > {16'd0, cfg.stall_timeout}) begin
                    rpm_we   = 1'b1;
                    rpm_next = '0;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (!last_grp) begin
                        gidx_next = gidx_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            gidx_reg     <= '0;
            time_reg     <= '0;
            since_reg    <= '0;
            div_cnt_reg  <= '0;
            power_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gidx_reg     <= gidx_next;
            time_reg     <= time_next;
            since_reg    <= since_next;
            div_cnt_reg  <= div_cnt_next;
            power_reg    <= power_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (out_load) begin
            m_tdata_reg <= {3'd0, power_reg, spd_reg[gidx_reg], rpm_reg[gidx_reg],
                            duty_reg[gidx_reg], 3'(gidx_reg)};
            m_tlast_reg <= last_grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUPS; g++) begin
                pulse_reg[g] <= '0;
                lvt_reg[g]   <= '0;
                rpm_reg[g]   <= '0;
                spd_reg[g]   <= '0;
                duty_reg[g]  <= '0;
            end
        end else begin
            if (pulse_we) pulse_reg[sel_idx] <= pulse_next;
            if (lvt_we)   lvt_reg[sel_idx]   <= lvt_next;
            if (rpm_we)   rpm_reg[sel_idx]   <= rpm_next;
            if (spd_we)   spd_reg[sel_idx]   <= spd_next;
            if (duty_we)  duty_reg[sel_idx]  <= duty_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_DIV |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV && div_cnt_reg == 5'd0) |=> state_reg == B_STALL)
        else $error("divider overran its step count");

    a_calc_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_CALC |-> cmd_reg.op == OP_TICK)
        else $error("RPM recalculation outside an update tick");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_grp) |=> state_reg == B_IDLE)
        else $error("engine busy after final result of a word");

endmodule

`default_nettype wire

[rtl/fan_tach_rpm_pwm_controller_unit.sv]
// Fan tach/PWM controller: decoupled front end, queue and execution engine.
// An accepted word is queued and dequeued once the engine is idle; set speed and power
// on/off then pass DUTY and EMIT per group, update ticks CALC, STALL and EMIT, with DIV
// after CALC for a group whose RPM is recomputed (32-step restoring divider).
// Words with no result are consumed in IDLE; a low m_tready holds the engine.
// Reset (aresetn low, synchronous): counters, group state and queue cleared,
// power off, configuration back to 1000 / 10 / 2000.
`default_nettype none

module fan_tach_rpm_pwm_controller_unit
    import fantc_pkg::*;
#(
    parameter int GROUPS = 2
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [2:0]             s_tuser,  // operation
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // group[2:0], speed[9:3], zero pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,  // out_group[2:0], duty[12:3],
                                                  // rpm[44:13], speed_now[51:45],
                                                  // power_on[52], zero pad
    output logic                        m_tlast,  // last
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [15:0]            cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_INTERVAL:   cfg_next.interval      = cfg_data;
                CFG_MIN_PULSES: cfg_next.min_pulses    = cfg_data;
                CFG_STALL:      cfg_next.stall_timeout = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interval      <= RST_INTERVAL;
            cfg_reg.min_pulses    <= RST_MIN_PULSES;
            cfg_reg.stall_timeout <= RST_STALL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fantc_front #(.GROUPS(GROUPS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    fantc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    fantc_back #(.GROUPS(GROUPS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
